// File: design/tlik_pkg.sv
package tlik_pkg;

  localparam int CordicStages = 16;
  localparam int Prescale = 30;
  localparam int CW = 62;
  localparam int SqW = 27;
  localparam int SqSteps = 14;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_z;
  } tlik_in_t;

  typedef struct packed {
    logic               reachable;
    logic signed [15:0] elbow_servo_angle;
    logic        [13:0] knee_servo_angle;
  } tlik_out_t;

  typedef enum logic [0:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } tlik_reg_t;

  function automatic logic signed [33:0] atan_step(input int i);
    logic signed [33:0] v;
    unique case (i)
      0: v = 34'sd536870912;
      1: v = 34'sd316933406;
      2: v = 34'sd167458907;
      3: v = 34'sd85004756;
      4: v = 34'sd42667331;
      5: v = 34'sd21354465;
      6: v = 34'sd10679838;
      7: v = 34'sd5340245;
      8: v = 34'sd2670163;
      9: v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      24: v = 34'sd41;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      28: v = 34'sd3;
      29: v = 34'sd1;
      30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/two_link_inverse_kinematics.sv
// channel | dir | handshake            | payload
// in_     | in  | start & !busy        | tlik_in_t (target_x, target_z)
// out_    | out | out_valid, 1 cycle   | tlik_out_t
// cfg_    | in  | cfg_valid & cfg_ready| cfg_index, cfg_data (13 bit link length)
// One target per cycle; each passes stages A, B and C, the square root, the CORDIC and the output register.
// Pipeline depth is set mostly by the 14-step pipelined square root and the 16-stage CORDIC.
// Reset (rst_n low, synchronous) clears valid bits and sets both links to 3200.
// Busy stays low: the receiver cannot stall and the pipeline never holds.
module two_link_inverse_kinematics
  import tlik_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  tlik_in_t    in_data,
  output logic        out_valid,
  output tlik_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int Lat = 2 + SqSteps + 3 + CordicStages + 1;

  logic [12:0] l1_r, l2_r;
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= 13'd3200;
      l2_r <= 13'd3200;
    end else if (cfg_valid) begin
      unique case (tlik_reg_t'(cfg_index))
        REG_UPPER: l1_r <= cfg_data;
        REG_LOWER: l2_r <= cfg_data;
      endcase
    end
  end

  // stage A: squares
  logic               va_r;
  logic signed [15:0] xa_r, za_r;
  logic [31:0]        x2_r, z2_r, l1s_r, l2s_r;
  logic [13:0]        sum_r;
  logic [12:0]        dif_r;
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= start;
    xa_r  <= in_data.target_x;
    za_r  <= in_data.target_z;
    x2_r  <= 32'(in_data.target_x * in_data.target_x);
    z2_r  <= 32'(in_data.target_z * in_data.target_z);
    l1s_r <= 32'(l1_r * l1_r);
    l2s_r <= 32'(l2_r * l2_r);
    sum_r <= 14'(l1_r) + 14'(l2_r);
    dif_r <= (l1_r > l2_r) ? l1_r - l2_r : l2_r - l1_r;
  end

  // stage B: d2, range test, c_num, k parts
  logic               vb_r, okb_r;
  logic signed [15:0] xb_r, zb_r;
  logic signed [34:0] cn_r, bn_r;
  logic [53:0]        k4_r;
  logic [31:0]        d2w;
  logic signed [34:0] cnw;
  always_comb begin
    d2w = x2_r + z2_r;
    cnw = $signed({3'b0, d2w}) - $signed({3'b0, l1s_r}) - $signed({3'b0, l2s_r});
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else vb_r <= va_r;
    xb_r  <= xa_r;
    zb_r  <= za_r;
    okb_r <= !(33'(d2w) > 33'(sum_r) * 33'(sum_r)) && !(d2w < 32'(dif_r) * 32'(dif_r));
    cn_r  <= cnw;
    bn_r  <= $signed({3'b0, d2w}) + $signed({3'b0, l1s_r}) - $signed({3'b0, l2s_r});
    k4_r  <= 54'(l1s_r[25:0] * l2s_r[25:0]) << 2;
  end

  // stage C: k = 4 l1s l2s - cn^2, clamped at zero
  logic               vc_r, okc_r;
  logic signed [15:0] xc_r, zc_r;
  logic signed [34:0] cnc_r, bnc_r;
  logic [53:0]        k_r;
  logic [33:0]        acn;
  assign acn = cn_r[34] ? 34'(-cn_r) : cn_r[33:0];
  logic [67:0] csq;
  assign csq = {34'b0, acn} * {34'b0, acn};
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else vc_r <= vb_r;
    xc_r  <= xb_r;
    zc_r  <= zb_r;
    okc_r <= okb_r;
    cnc_r <= cn_r;
    bnc_r <= bn_r;
    k_r   <= (68'(k4_r) > csq) ? 54'(68'(k4_r) - csq) : '0;
  end

  // integer square root, two result bits per stage
  logic [53:0]        sv_r [SqSteps+1];
  logic [SqW-1:0]     sr_r [SqSteps+1];
  logic               sq_v_r [SqSteps+1];
  logic               sq_ok_r [SqSteps+1];
  logic signed [15:0] sq_x_r [SqSteps+1], sq_z_r [SqSteps+1];
  logic signed [34:0] sq_c_r [SqSteps+1], sq_b_r [SqSteps+1];
  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else sq_v_r[0] <= vc_r;
    sv_r[0]    <= k_r;
    sr_r[0]    <= '0;
    sq_ok_r[0] <= okc_r;
    sq_x_r[0]  <= xc_r;
    sq_z_r[0]  <= zc_r;
    sq_c_r[0]  <= cnc_r;
    sq_b_r[0]  <= bnc_r;
  end
  for (genvar j = 0; j < SqSteps; j++) begin : g_sq
    localparam int B = SqW - 1 - 2 * j;
    logic [53:0] trial [2];
    logic [53:0] rem [3];
    logic [SqW-1:0] rt [3];
    always_comb begin
      rem[0] = sv_r[j];
      rt[0]  = sr_r[j];
      for (int t = 0; t < 2; t++) begin
        if (B - t >= 0) begin
          trial[t] = (54'(rt[t]) << (B - t + 1)) + (54'(1) << (2 * (B - t)));
          if (rem[t] >= trial[t]) begin
            rem[t+1] = rem[t] - trial[t];
            rt[t+1]  = rt[t] | (SqW'(1) << (B - t));
          end else begin
            rem[t+1] = rem[t];
            rt[t+1]  = rt[t];
          end
        end else begin
          trial[t] = '0;
          rem[t+1] = rem[t];
          rt[t+1]  = rt[t];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j+1] <= 1'b0;
      else sq_v_r[j+1] <= sq_v_r[j];
      sv_r[j+1]    <= rem[2];
      sr_r[j+1]    <= rt[2];
      sq_ok_r[j+1] <= sq_ok_r[j];
      sq_x_r[j+1]  <= sq_x_r[j];
      sq_z_r[j+1]  <= sq_z_r[j];
      sq_c_r[j+1]  <= sq_c_r[j];
      sq_b_r[j+1]  <= sq_b_r[j];
    end
  end

  logic signed [29:0] s_op;
  assign s_op = $signed({3'b0, sr_r[SqSteps]});

  logic signed [33:0] knee_a, beta_a, alpha_a;
  tlik_cordic u_knee (.clk, .y_in(s_op), .x_in(30'(sq_c_r[SqSteps])), .ang_out(knee_a));
  tlik_cordic u_beta (.clk, .y_in(s_op), .x_in(30'(sq_b_r[SqSteps])), .ang_out(beta_a));
  tlik_cordic u_alpha (.clk, .y_in(30'(sq_z_r[SqSteps])), .x_in(30'(sq_x_r[SqSteps])),
                       .ang_out(alpha_a));

  logic ok_d_r [CordicStages+1];
  logic v_d_r  [CordicStages+1];
  always_ff @(posedge clk) begin
    if (!rst_n) v_d_r[0] <= 1'b0;
    else v_d_r[0] <= sq_v_r[SqSteps];
    ok_d_r[0] <= sq_ok_r[SqSteps];
  end
  for (genvar k = 0; k < CordicStages; k++) begin : g_d
    always_ff @(posedge clk) begin
      if (!rst_n) v_d_r[k+1] <= 1'b0;
      else v_d_r[k+1] <= v_d_r[k];
      ok_d_r[k+1] <= ok_d_r[k];
    end
  end

  // conversion to 1/64 degree
  logic signed [35:0] ea, ka;
  logic signed [51:0] ep, kp;
  logic signed [19:0] ed, kd;
  assign ea = 36'sd1073741824 - (36'(alpha_a) - 36'(beta_a));
  assign ka = 36'sd2147483648 - 36'(knee_a);
  assign ep = 52'(ea) * 52'sd23040 + 52'sd2147483648;
  assign kp = 52'(ka) * 52'sd23040 + 52'sd2147483648;
  assign ed = 20'(ep >>> 32);
  assign kd = 20'(kp >>> 32);

  tlik_out_t res;
  always_comb begin
    res.reachable = ok_d_r[CordicStages];
    if (ed < -20'sd5760) res.elbow_servo_angle = -16'sd5760;
    else if (ed > 20'sd28800) res.elbow_servo_angle = 16'sd28800;
    else res.elbow_servo_angle = 16'(ed);
    if (kd < 0) res.knee_servo_angle = '0;
    else if (kd > 20'sd11520) res.knee_servo_angle = 14'd11520;
    else res.knee_servo_angle = 14'(kd);
    if (!ok_d_r[CordicStages]) begin
      res.elbow_servo_angle = '0;
      res.knee_servo_angle  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= v_d_r[CordicStages];
    out_data <= res;
  end

  logic [Lat-1:0] vhist_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vhist_r <= '0;
    else vhist_r <= {vhist_r[Lat-2:0], start};
  end

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == vhist_r[Lat-1]) else $error("result beat out of step with input");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reachable |-> out_data.elbow_servo_angle == '0 &&
    out_data.knee_servo_angle == '0) else $error("unreachable result not zero");
  a_knee: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.knee_servo_angle <= 14'd11520) else $error("knee out of range");

endmodule

// File: design/tlik_cordic.sv
module tlik_cordic
  import tlik_pkg::*;
(
  input  logic               clk,
  input  logic signed [29:0] y_in,
  input  logic signed [29:0] x_in,
  output logic signed [33:0] ang_out
);

  logic signed [CW-1:0] x_r [CordicStages+1];
  logic signed [CW-1:0] y_r [CordicStages+1];
  logic signed [33:0]   a_r [CordicStages+1];
  logic                 sp_r [CordicStages+1];
  logic signed [33:0]   sa_r [CordicStages+1];

  logic signed [33:0] a0;
  logic signed [29:0] x0, y0;
  logic               sp0;
  logic signed [33:0] sa0;

  always_comb begin
    a0  = '0;
    x0  = x_in;
    y0  = y_in;
    sp0 = 1'b0;
    sa0 = '0;
    if (y_in == '0) begin
      sp0 = 1'b1;
      sa0 = (x_in < 0) ? 34'sd2147483648 : 34'sd0;
    end else if (x_in == '0) begin
      sp0 = 1'b1;
      sa0 = (y_in > 0) ? 34'sd1073741824 : -34'sd1073741824;
    end else if (x_in < 0) begin
      a0 = (y_in > 0) ? 34'sd2147483648 : -34'sd2147483648;
      x0 = -x_in;
      y0 = -y_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]  <= CW'(x0) <<< Prescale;
    y_r[0]  <= CW'(y0) <<< Prescale;
    a_r[0]  <= a0;
    sp_r[0] <= sp0;
    sa_r[0] <= sa0;
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] + atan_step(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        a_r[i+1] <= a_r[i] - atan_step(i);
      end
      sp_r[i+1] <= sp_r[i];
      sa_r[i+1] <= sa_r[i];
    end
  end

  assign ang_out = sp_r[CordicStages] ? sa_r[CordicStages] : a_r[CordicStages];

endmodule
